// ===== rtl/dbsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsr_pkg
// Shared types and constants for the distance banded speed ramp.
// ----------------------------------------------------------------------------
package dbsr_pkg;

    localparam int TICKS_W    = 16;
    localparam int CM_W       = 11;
    localparam int SUM_W      = 12;
    localparam int IDX_W      = 2;
    localparam int LEVEL_W    = 8;
    localparam int OFFSET_W   = 4;
    localparam int SPEED_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // ticks / 58 == (ticks >> 1) / 29, done as multiply by ceil(2^21 / 29)
    localparam int                CM_SHIFT = 21;
    localparam logic [16:0]       CM_RECIP = 17'd72316;

    // level * 300 / 255 == level * 20 / 17, as multiply by 20 * ceil(2^18 / 17)
    localparam int                SPEED_SHIFT = 18;
    localparam logic [18:0]       SPEED_MUL   = 19'd308420;

    // distance bands
    localparam logic [CM_W-1:0]    BAND0_CM    = 11'd30;
    localparam logic [CM_W-1:0]    BAND1_CM    = 11'd45;
    localparam logic [CM_W-1:0]    BAND2_CM    = 11'd60;
    localparam logic [CM_W-1:0]    BAND3_CM    = 11'd90;
    localparam logic [LEVEL_W-1:0] BAND0_LEVEL = 8'd80;
    localparam logic [LEVEL_W-1:0] BAND1_LEVEL = 8'd130;
    localparam logic [LEVEL_W-1:0] BAND2_LEVEL = 8'd180;
    localparam logic [LEVEL_W-1:0] BAND3_LEVEL = 8'd220;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_DISTANCE   = 3'd0,
        REG_MIN_START_LEVEL = 3'd1,
        REG_STEP_UP         = 3'd2,
        REG_STEP_DOWN       = 3'd3,
        REG_RIGHT_OFFSET    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CM_W-1:0]     stop_distance;
        logic [LEVEL_W-1:0]  min_start_level;
        logic [LEVEL_W-1:0]  step_up;
        logic [LEVEL_W-1:0]  step_down;
        logic [OFFSET_W-1:0] right_offset;
    } cfg_t;

    // handshake between front end and queue, and queue and back end
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } sum_xfer_t;

endpackage

// ===== rtl/distance_banded_speed_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_banded_speed_ramp
// Averages ultrasonic echoes into a distance and ramps a motor drive level.
//
//   channel   signals                         direction
//   echo      echo_valid/echo_ready           in
//   result    result_valid/result_ready       out
//   config    cfg_wr_en/cfg_index/cfg_data    in, write only
//
// one echo accepted per cycle while the queue has room; a reading result is
// registered through cm multiply, accumulate, average multiply and level
// the drive level register loops back through the ramp, as the echo sum does
// reset clears all control state, the running sum and the level; no clearing pass
// a two-entry queue separates accumulation from the ramp so a stalled result
// port backs up into the echo port only once the queue is full
// ----------------------------------------------------------------------------
module distance_banded_speed_ramp
    import dbsr_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   echo_valid,
    output logic                   echo_ready,
    input  logic [TICKS_W-1:0]     echo_ticks,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [CM_W-1:0]        distance_cm,
    output logic [LEVEL_W-1:0]     target_level,
    output logic [LEVEL_W-1:0]     drive_level,
    output logic [LEVEL_W-1:0]     left_drive,
    output logic [LEVEL_W-1:0]     right_drive,
    output logic [SPEED_W-1:0]     speed_cm_per_hour
);

    cfg_t      cfg_reg;
    sum_xfer_t push;
    sum_xfer_t head;
    logic      q_full;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_distance   <= 11'd20;
            cfg_reg.min_start_level <= 8'd40;
            cfg_reg.step_up         <= 8'd3;
            cfg_reg.step_down       <= 8'd35;
            cfg_reg.right_offset    <= 4'd2;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STOP_DISTANCE:   cfg_reg.stop_distance   <= cfg_data;
                REG_MIN_START_LEVEL: cfg_reg.min_start_level <= cfg_data[LEVEL_W-1:0];
                REG_STEP_UP:         cfg_reg.step_up         <= cfg_data[LEVEL_W-1:0];
                REG_STEP_DOWN:       cfg_reg.step_down       <= cfg_data[LEVEL_W-1:0];
                REG_RIGHT_OFFSET:    cfg_reg.right_offset    <= cfg_data[OFFSET_W-1:0];
                default:             ;
            endcase
        end
    end

    dbsr_front #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .echo_valid (echo_valid),
        .echo_ready (echo_ready),
        .echo_ticks (echo_ticks),
        .push       (push),
        .q_full     (q_full)
    );

    dbsr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    dbsr_back #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .head              (head),
        .pop               (pop),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .distance_cm       (distance_cm),
        .target_level      (target_level),
        .drive_level       (drive_level),
        .left_drive        (left_drive),
        .right_drive       (right_drive),
        .speed_cm_per_hour (speed_cm_per_hour)
    );

`ifndef NO_ASSERTIONS
    // a zero target only comes from the stop test, which forces the level to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (target_level == '0) |-> (drive_level == '0))
        else $error("nonzero drive with zero target");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (right_drive >= drive_level) && (left_drive == drive_level))
        else $error("motor drives inconsistent with drive level");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (speed_cm_per_hour <= SPEED_W'(300)))
        else $error("speed out of range");

    // the level only moves when a new result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(drive_level))
        else $error("drive level changed under a stalled result");
`endif

endmodule

// ===== rtl/dbsr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsr_front
// Converts echo ticks to cm, accumulates echoes and pushes one sum per reading.
// ----------------------------------------------------------------------------
module dbsr_front
    import dbsr_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 echo_valid,
    output logic                 echo_ready,
    input  logic [TICKS_W-1:0]   echo_ticks,
    output sum_xfer_t            push,
    input  logic                 q_full
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_READING - 1);

    logic                a_valid_reg, a_valid_next;
    logic [CM_W-1:0]     cm_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [31:0]         cm_prod;
    logic [SUM_W-1:0]    sum_add;
    logic                is_last;
    logic                a_fire;
    logic                echo_xfer;

    assign cm_prod   = 32'(echo_ticks[TICKS_W-1:1]) * 32'(CM_RECIP);
    assign sum_add   = sum_reg + SUM_W'(cm_reg);
    assign is_last   = (idx_reg == LAST_IDX);
    assign a_fire    = a_valid_reg && (!is_last || !q_full);
    assign echo_ready = !a_valid_reg || a_fire;
    assign echo_xfer = echo_valid && echo_ready;

    assign push.valid = a_valid_reg && is_last && !q_full;
    assign push.sum   = sum_add;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        if (a_fire)
        begin
            a_valid_next = 1'b0;
            if (is_last)
            begin
                sum_next = '0;
                idx_next = '0;
            end
            else
            begin
                sum_next = sum_add;
                idx_next = idx_reg + 1'b1;
            end
        end
        if (echo_xfer)
        begin
            a_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            sum_reg     <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            sum_reg     <= sum_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (echo_xfer)
        begin
            cm_reg <= cm_prod[CM_SHIFT +: CM_W];
        end
    end

endmodule

// ===== rtl/dbsr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsr_queue
// Two-entry queue of reading sums between front end and back end.
// ----------------------------------------------------------------------------
module dbsr_queue
    import dbsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sum_xfer_t  push,
    output logic       full,
    output sum_xfer_t  head,
    input  logic       pop
);

    logic [SUM_W-1:0]  mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.sum   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.sum;
        end
    end

endmodule

// ===== rtl/dbsr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsr_back
// Averages a reading, picks the band target and ramps the drive level.
// ----------------------------------------------------------------------------
module dbsr_back
    import dbsr_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  sum_xfer_t           head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [CM_W-1:0]     distance_cm,
    output logic [LEVEL_W-1:0]  target_level,
    output logic [LEVEL_W-1:0]  drive_level,
    output logic [LEVEL_W-1:0]  left_drive,
    output logic [LEVEL_W-1:0]  right_drive,
    output logic [SPEED_W-1:0]  speed_cm_per_hour
);

    // sum / SAMPLES_PER_READING as multiply by ceil(2^13 / n), exact below 4096
    localparam int AVG_SHIFT  = 13;
    localparam int AVG_RECIP  = (2**AVG_SHIFT + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
    localparam int AVG_RW     = AVG_SHIFT + 1;
    localparam int AVG_PW     = SUM_W + AVG_RW;

    logic                b1_valid_reg, b1_valid_next;
    logic [CM_W-1:0]     dist_reg;
    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [CM_W-1:0]     dist_out_reg;
    logic [LEVEL_W-1:0]  target_out_reg;
    logic [LEVEL_W-1:0]  right_out_reg;
    logic [SPEED_W-1:0]  speed_out_reg;

    logic [AVG_PW-1:0]   avg_prod;
    logic                adv;
    logic                at_stop;
    logic [LEVEL_W-1:0]  target;
    logic [LEVEL_W:0]    up_sum;
    logic [LEVEL_W:0]    right_sum;
    logic [LEVEL_W-1:0]  right_sat;
    logic [26:0]         speed_prod;

    assign avg_prod = AVG_PW'(head.sum) * AVG_PW'(AVG_RECIP);
    assign adv      = b1_valid_reg && (!out_valid_reg || result_ready);
    assign pop      = head.valid && (!b1_valid_reg || adv);

    // band target, stop test first
    assign at_stop = (dist_reg <= cfg.stop_distance);
    always_comb
    begin
        if (at_stop)
            target = '0;
        else if (dist_reg <= BAND0_CM)
            target = BAND0_LEVEL;
        else if (dist_reg <= BAND1_CM)
            target = BAND1_LEVEL;
        else if (dist_reg <= BAND2_CM)
            target = BAND2_LEVEL;
        else if (dist_reg <= BAND3_CM)
            target = BAND3_LEVEL;
        else
            target = LEVEL_MAX;
    end

    // level ramp
    assign up_sum = {1'b0, level_reg} + {1'b0, cfg.step_up};
    always_comb
    begin
        if (at_stop)
            level_next = '0;
        else if (level_reg < target)
        begin
            if (level_reg < cfg.min_start_level)
                level_next = cfg.min_start_level;
            else if (up_sum[LEVEL_W])
                level_next = LEVEL_MAX;
            else
                level_next = up_sum[LEVEL_W-1:0];
        end
        else if (level_reg > target)
        begin
            if (level_reg > cfg.step_down)
                level_next = level_reg - cfg.step_down;
            else
                level_next = '0;
        end
        else
            level_next = level_reg;
    end

    assign right_sum  = {1'b0, level_next} + (LEVEL_W + 1)'(cfg.right_offset);
    assign right_sat  = right_sum[LEVEL_W] ? LEVEL_MAX : right_sum[LEVEL_W-1:0];
    assign speed_prod = 27'(level_next) * 27'(SPEED_MUL);

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        if (adv)
            b1_valid_next = 1'b0;
        if (pop)
            b1_valid_next = 1'b1;
        out_valid_next = out_valid_reg;
        if (result_valid && result_ready)
            out_valid_next = 1'b0;
        if (adv)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
                level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            dist_reg <= avg_prod[AVG_SHIFT +: CM_W];
        if (adv)
        begin
            dist_out_reg   <= dist_reg;
            target_out_reg <= target;
            right_out_reg  <= right_sat;
            speed_out_reg  <= speed_prod[SPEED_SHIFT +: SPEED_W];
        end
    end

    assign result_valid      = out_valid_reg;
    assign distance_cm       = dist_out_reg;
    assign target_level      = target_out_reg;
    assign drive_level       = level_reg;
    assign left_drive        = level_reg;
    assign right_drive       = right_out_reg;
    assign speed_cm_per_hour = speed_out_reg;

endmodule

// ===== test/distance_banded_speed_ramp_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_banded_speed_ramp_test
// Self-checking bench for the echo-averaging speed ramp. A directed table of
// echoes, some with hand-worked readings, then random phases, each under its
// own register setting. Both handshakes see random gaps and stalls. Readings
// are checked field by field against hand values or a bench model of the ramp.
// ----------------------------------------------------------------------------
module distance_banded_speed_ramp_test;

    import dbsr_pkg::*;

    localparam int READING_LEN   = 3;
    localparam int TICKS_PER_CM  = 58;
    localparam int SPEED_FULL    = 300;
    localparam int PHASES        = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;

    typedef struct packed {
        logic [CM_W-1:0]    distance;
        logic [LEVEL_W-1:0] target;
        logic [LEVEL_W-1:0] drive;
        logic [LEVEL_W-1:0] left;
        logic [LEVEL_W-1:0] right;
        logic [SPEED_W-1:0] speed;
    } reading_t;

    typedef struct {
        logic [TICKS_W-1:0] ticks;
        bit                 typed;
        reading_t           want;
    } echo_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  echo_valid;
    logic                  echo_ready;
    logic [TICKS_W-1:0]    echo_ticks;
    logic                  result_valid;
    logic                  result_ready;
    logic [CM_W-1:0]       distance_cm;
    logic [LEVEL_W-1:0]    target_level;
    logic [LEVEL_W-1:0]    drive_level;
    logic [LEVEL_W-1:0]    left_drive;
    logic [LEVEL_W-1:0]    right_drive;
    logic [SPEED_W-1:0]    speed_cm_per_hour;

    // bench copy of the ramp state and registers
    cfg_t               ramp_regs;
    logic [IDX_W-1:0]   echoes_in_reading;
    logic [SUM_W-1:0]   cm_sum;
    logic [LEVEL_W-1:0] level_now;

    reading_t  readings_due[$];
    echo_row_t echo_table[$];

    int mismatches;
    int walk_cm;
    int source_burst;
    int sink_burst;
    int sink_stall;
    int idle_cycles;

    distance_banded_speed_ramp #(
        .SAMPLES_PER_READING(READING_LEN)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .echo_valid       (echo_valid),
        .echo_ready       (echo_ready),
        .echo_ticks       (echo_ticks),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .distance_cm      (distance_cm),
        .target_level     (target_level),
        .drive_level      (drive_level),
        .left_drive       (left_drive),
        .right_drive      (right_drive),
        .speed_cm_per_hour(speed_cm_per_hour)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int source_gap();
        if (source_burst > 0)
        begin
            source_burst--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            source_burst = $urandom_range(20, 60);
            return 0;
        end
        return gap_len();
    endfunction

    function automatic reading_t typed_reading(int dist_val, int tgt, int lvl, int rgt, int spd);
        reading_t r;
        r.distance = CM_W'(dist_val);
        r.target   = LEVEL_W'(tgt);
        r.drive    = LEVEL_W'(lvl);
        r.left     = LEVEL_W'(lvl);
        r.right    = LEVEL_W'(rgt);
        r.speed    = SPEED_W'(spd);
        return r;
    endfunction

    task automatic add_row(input logic [TICKS_W-1:0] ticks, input bit typed, input reading_t want);
        echo_row_t row;
        row.ticks = ticks;
        row.typed = typed;
        row.want  = want;
        echo_table.push_back(row);
    endtask

    // one echo into the bench model; a full reading yields the expected result
    task automatic ramp_echo(input logic [TICKS_W-1:0] ticks, output bit done,
                             output reading_t r);
        int avg_cm;
        int tgt;
        int lvl;
        int rgt;
        done = 1'b0;
        r = '0;
        cm_sum = cm_sum + SUM_W'(ticks / TICKS_PER_CM);
        echoes_in_reading = echoes_in_reading + 1'b1;
        if (echoes_in_reading < READING_LEN)
            return;
        avg_cm = int'(cm_sum) / READING_LEN;
        cm_sum = '0;
        echoes_in_reading = '0;

        if (avg_cm <= ramp_regs.stop_distance)
            tgt = 0;
        else if (avg_cm <= BAND0_CM)
            tgt = BAND0_LEVEL;
        else if (avg_cm <= BAND1_CM)
            tgt = BAND1_LEVEL;
        else if (avg_cm <= BAND2_CM)
            tgt = BAND2_LEVEL;
        else if (avg_cm <= BAND3_CM)
            tgt = BAND3_LEVEL;
        else
            tgt = LEVEL_MAX;

        lvl = level_now;
        if (avg_cm <= ramp_regs.stop_distance)
            lvl = 0;
        else if (lvl < tgt)
        begin
            // a start from below the minimum jumps there, even past the target
            if (lvl < ramp_regs.min_start_level)
                lvl = ramp_regs.min_start_level;
            else
                lvl = lvl + ramp_regs.step_up;
        end
        else if (lvl > tgt)
            lvl = (lvl > ramp_regs.step_down) ? lvl - ramp_regs.step_down : 0;
        if (lvl > LEVEL_MAX)
            lvl = LEVEL_MAX;
        level_now = LEVEL_W'(lvl);

        rgt = lvl + ramp_regs.right_offset;
        if (rgt > LEVEL_MAX)
            rgt = LEVEL_MAX;

        r = typed_reading(avg_cm, tgt, lvl, rgt, lvl * SPEED_FULL / LEVEL_MAX);
        done = 1'b1;
    endtask

    task automatic send_echo(input logic [TICKS_W-1:0] ticks, input bit typed,
                             input reading_t want);
        int gap;
        bit done;
        reading_t r;
        gap = source_gap();
        if (gap > 0)
        begin
            echo_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        echo_valid <= 1'b1;
        echo_ticks <= ticks;
        do
            @(posedge clk);
        while (!echo_ready);
        ramp_echo(ticks, done, r);
        if (done)
            readings_due.push_back(typed ? want : r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_STOP_DISTANCE:   ramp_regs.stop_distance   = data[CM_W-1:0];
            REG_MIN_START_LEVEL: ramp_regs.min_start_level = data[LEVEL_W-1:0];
            REG_STEP_UP:         ramp_regs.step_up         = data[LEVEL_W-1:0];
            REG_STEP_DOWN:       ramp_regs.step_down       = data[LEVEL_W-1:0];
            REG_RIGHT_OFFSET:    ramp_regs.right_offset    = data[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    // only while idle: drain every reading, then let the pipeline empty
    task automatic program_regs(input logic [CFG_DATA_W-1:0] stop, input logic [CFG_DATA_W-1:0] min_lvl,
                                input logic [CFG_DATA_W-1:0] up, input logic [CFG_DATA_W-1:0] down,
                                input logic [CFG_DATA_W-1:0] offset);
        echo_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        // an unused index must leave every register alone
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_RIGHT_OFFSET) + 1, 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)));
        write_reg(REG_STOP_DISTANCE, stop);
        write_reg(REG_MIN_START_LEVEL, min_lvl);
        write_reg(REG_STEP_UP, up);
        write_reg(REG_STEP_DOWN, down);
        write_reg(REG_RIGHT_OFFSET, offset);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [TICKS_W-1:0] pick_echo();
        int r;
        int cm;
        r = $urandom_range(0, 99);
        if (r < 6)
            return TICKS_W'($urandom_range(0, 2 ** TICKS_W - 1));
        if (r < 8)
            return '1;
        if (r < 10)
            return '0;
        cm = walk_cm + int'($urandom_range(0, 4)) - 2;
        if (cm < 0)
            cm = 0;
        return TICKS_W'(cm * TICKS_PER_CM + int'($urandom_range(0, TICKS_PER_CM - 1)));
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result side: check each transfer, then stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected reading, expected none, actual distance %0d",
                             $time, distance_cm);
                    mismatches++;
                end
                else
                begin
                    check_field("distance_cm", readings_due[0].distance, distance_cm);
                    check_field("target_level", readings_due[0].target, target_level);
                    check_field("drive_level", readings_due[0].drive, drive_level);
                    check_field("left_drive", readings_due[0].left, left_drive);
                    check_field("right_drive", readings_due[0].right, right_drive);
                    check_field("speed_cm_per_hour", readings_due[0].speed, speed_cm_per_hour);
                    void'(readings_due.pop_front());
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (sink_burst > 0)
                    sink_burst--;
                else if ($urandom_range(0, 199) == 0)
                    sink_burst = $urandom_range(100, 300);
                else if ($urandom_range(0, 7) == 0)
                    sink_stall = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((echo_valid && echo_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("distance_banded_speed_ramp_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int count;
        reading_t none;

        none         = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        source_burst = 0;
        sink_burst   = 0;
        sink_stall   = 0;
        walk_cm      = 25;
        rst_n        = 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= REG_STOP_DISTANCE;
        cfg_data   <= '0;
        echo_valid <= 1'b0;
        echo_ticks <= '0;

        ramp_regs.stop_distance   = 11'd20;
        ramp_regs.min_start_level = 8'd40;
        ramp_regs.step_up         = 8'd3;
        ramp_regs.step_down       = 8'd35;
        ramp_regs.right_offset    = 4'd2;
        echoes_in_reading = '0;
        cm_sum            = '0;
        level_now         = '0;

        // directed echoes under the reset register values
        add_row(16'd0, 1'b0, none);
        add_row(16'd0, 1'b0, none);
        add_row(16'd0, 1'b1, typed_reading(0, 0, 0, 2, 0));
        add_row(16'd65535, 1'b0, none);
        add_row(16'd65535, 1'b0, none);
        add_row(16'd65535, 1'b1, typed_reading(1129, 255, 40, 42, 47));
        add_row(16'd65535, 1'b0, none);
        add_row(16'd65535, 1'b0, none);
        add_row(16'd65535, 1'b1, typed_reading(1129, 255, 43, 45, 50));
        // exactly at the stop distance, then one above it
        add_row(16'd1160, 1'b0, none);
        add_row(16'd1160, 1'b0, none);
        add_row(16'd1160, 1'b1, typed_reading(20, 0, 0, 2, 0));
        add_row(16'd1218, 1'b0, none);
        add_row(16'd1218, 1'b0, none);
        add_row(16'd1218, 1'b1, typed_reading(21, 80, 40, 42, 47));
        // at and near band edges, with truncation in both divides
        add_row(16'd1740, 1'b0, none);
        add_row(16'd1797, 1'b0, none);
        add_row(16'd1741, 1'b0, none);
        add_row(16'd2610, 1'b0, none);
        add_row(16'd2667, 1'b0, none);
        add_row(16'd2553, 1'b0, none);
        add_row(16'd3480, 1'b0, none);
        add_row(16'd3480, 1'b0, none);
        add_row(16'd3537, 1'b0, none);
        add_row(16'd5220, 1'b0, none);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (echo_table[i])
            send_echo(echo_table[i].ticks, echo_table[i].typed, echo_table[i].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: ;
                1: program_regs(11'd0, 11'd0, 11'd255, 11'd255, 11'd15);
                // data wider than the register keeps only its low bits
                2: program_regs('1, '1, 11'h700, 11'd0, 11'h7F0);
                // stop distance above the first two bands
                3: program_regs(11'd60, 11'd255, 11'd1, 11'd1, 11'd15);
                4: program_regs(11'd20, 11'd40, 11'd3, 11'd35, 11'd2);
                default:
                    program_regs(($urandom_range(0, 9) == 0)
                                     ? CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1))
                                     : CFG_DATA_W'($urandom_range(0, 100)),
                                 CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)),
                                 CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)),
                                 CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)),
                                 CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)));
            endcase
            count = $urandom_range(80, 110);
            for (n = 0; n < count; n++)
            begin
                // slow drift in distance so the level ramps, with rare jumps
                if ($urandom_range(0, 32) == 0)
                    walk_cm = $urandom_range(0, 140);
                else if ($urandom_range(0, 2) == 0)
                    walk_cm = walk_cm + int'($urandom_range(0, 12)) - 6;
                if (walk_cm < 0)
                    walk_cm = 0;
                if (walk_cm > 140)
                    walk_cm = 140;
                send_echo(pick_echo(), 1'b0, none);
            end
        end

        echo_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("distance_banded_speed_ramp_test: done, clean");
        else
            $display("distance_banded_speed_ramp_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dbsr_pkg.sv
rtl/dbsr_front.sv
rtl/dbsr_queue.sv
rtl/dbsr_back.sv
rtl/distance_banded_speed_ramp.sv
test/distance_banded_speed_ramp_test.sv
